@@ src/ballc_pkg.sv @@
`default_nettype none

package ballc_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned RAD_BITS       = WORD_BITS - 1;
  localparam int unsigned IN_BITS        = 8 * WORD_BITS + 2 * RAD_BITS;
  localparam int unsigned IN_TDATA_BITS  = (IN_BITS + 7) / 8 * 8;
  localparam int unsigned OUT_TDATA_BITS = (WORD_BITS + 7) / 8 * 8;

  localparam int unsigned OFF_A_POS_X = 0;
  localparam int unsigned OFF_A_POS_Y = WORD_BITS;
  localparam int unsigned OFF_A_VEL_X = 2 * WORD_BITS;
  localparam int unsigned OFF_A_VEL_Y = 3 * WORD_BITS;
  localparam int unsigned OFF_A_RAD   = 4 * WORD_BITS;
  localparam int unsigned OFF_B_POS_X = 4 * WORD_BITS + RAD_BITS;
  localparam int unsigned OFF_B_POS_Y = 5 * WORD_BITS + RAD_BITS;
  localparam int unsigned OFF_B_VEL_X = 6 * WORD_BITS + RAD_BITS;
  localparam int unsigned OFF_B_VEL_Y = 7 * WORD_BITS + RAD_BITS;
  localparam int unsigned OFF_B_RAD   = 8 * WORD_BITS + RAD_BITS;

  localparam int unsigned DIFF_BITS    = WORD_BITS + 1;
  localparam int unsigned HALF_BITS    = WORD_BITS + 1;
  localparam int unsigned MAG_BITS     = 2 * HALF_BITS;
  localparam int unsigned A_BITS       = MAG_BITS;
  localparam int unsigned B_BITS       = MAG_BITS + 1;
  localparam int unsigned PROD_BITS    = 2 * MAG_BITS;
  localparam int unsigned DISC_BITS    = PROD_BITS + 1;
  localparam int unsigned SQ_DIGITS    = (PROD_BITS + 2 * FRAC_BITS + 1) / 2;
  localparam int unsigned RAD_IN_BITS  = 2 * SQ_DIGITS;
  localparam int unsigned M_BITS       =
      ((B_BITS + FRAC_BITS > SQ_DIGITS + 1) ? B_BITS + FRAC_BITS : SQ_DIGITS + 1) + 1;
  localparam int unsigned MU_BITS      = M_BITS - 1;
  localparam int unsigned DV_BITS      =
      ((MU_BITS > A_BITS + WORD_BITS) ? MU_BITS : A_BITS + WORD_BITS) + 1;

  typedef struct packed {
    logic                     hit;
    logic                     enter;
    logic [A_BITS-1:0]        a;
    logic signed [B_BITS-1:0] b;
  } sq_side_t;

  typedef struct packed {
    logic hit;
    logic sat;
  } dv_side_t;

endpackage

`default_nettype wire

@@ src/ballc_sqrt.sv @@
`default_nettype none

module ballc_sqrt import ballc_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic [RAD_IN_BITS-1:0] x_i,
  input  wire sq_side_t               side_i,
  output logic                        valid_o,
  output logic [SQ_DIGITS-1:0]        root_o,
  output logic                        exact_o,
  output sq_side_t                    side_o
);

  logic                   valid_q [SQ_DIGITS];
  logic [SQ_DIGITS+1:0]   rem_q   [SQ_DIGITS];
  logic [SQ_DIGITS-1:0]   root_q  [SQ_DIGITS];
  logic [RAD_IN_BITS-1:0] x_q     [SQ_DIGITS];
  sq_side_t               side_q  [SQ_DIGITS];

  logic [SQ_DIGITS+1:0]   rem_in  [SQ_DIGITS];
  logic [SQ_DIGITS-1:0]   root_in [SQ_DIGITS];
  logic [RAD_IN_BITS-1:0] x_in    [SQ_DIGITS];
  logic [SQ_DIGITS+1:0]   cur_c   [SQ_DIGITS];
  logic [SQ_DIGITS+1:0]   trial_c [SQ_DIGITS];
  logic                   ge_c    [SQ_DIGITS];
  logic [SQ_DIGITS+1:0]   rem_d   [SQ_DIGITS];
  logic [SQ_DIGITS-1:0]   root_d  [SQ_DIGITS];
  logic [RAD_IN_BITS-1:0] x_d     [SQ_DIGITS];

  always_comb begin
    rem_in[0]  = '0;
    root_in[0] = '0;
    x_in[0]    = x_i;
    for (int k = 1; k < SQ_DIGITS; k++) begin
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
      x_in[k]    = x_q[k-1];
    end
    for (int k = 0; k < SQ_DIGITS; k++) begin
      cur_c[k]   = {rem_in[k][SQ_DIGITS-1:0], x_in[k][RAD_IN_BITS-1 -: 2]};
      trial_c[k] = {root_in[k], 2'b01};
      ge_c[k]    = cur_c[k] >= trial_c[k];
      rem_d[k]   = ge_c[k] ? cur_c[k] - trial_c[k] : cur_c[k];
      root_d[k]  = {root_in[k][SQ_DIGITS-2:0], ge_c[k]};
      x_d[k]     = x_in[k] << 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SQ_DIGITS; k++) valid_q[k] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int k = 1; k < SQ_DIGITS; k++) valid_q[k] <= valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < SQ_DIGITS; k++) side_q[k] <= side_q[k-1];
      for (int k = 0; k < SQ_DIGITS; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        x_q[k]    <= x_d[k];
      end
    end
  end

  assign valid_o = valid_q[SQ_DIGITS-1];
  assign root_o  = root_q[SQ_DIGITS-1];
  assign exact_o = rem_q[SQ_DIGITS-1] == '0;
  assign side_o  = side_q[SQ_DIGITS-1];

endmodule

`default_nettype wire

@@ src/ballc_div.sv @@
`default_nettype none

module ballc_div import ballc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic [MU_BITS-1:0] m_i,
  input  wire logic [A_BITS-1:0]  a_i,
  input  wire dv_side_t           side_i,
  output logic                    valid_o,
  output logic [WORD_BITS-1:0]    q_o,
  output dv_side_t                side_o
);

  logic                 valid_q [WORD_BITS];
  logic [DV_BITS-1:0]   rem_q   [WORD_BITS];
  logic [WORD_BITS-1:0] quo_q   [WORD_BITS];
  logic [A_BITS-1:0]    a_q     [WORD_BITS];
  dv_side_t             side_q  [WORD_BITS];

  logic [DV_BITS-1:0]   rem_in  [WORD_BITS];
  logic [WORD_BITS-1:0] quo_in  [WORD_BITS];
  logic [A_BITS-1:0]    a_in    [WORD_BITS];
  logic [DV_BITS-1:0]   sh_c    [WORD_BITS];
  logic                 ge_c    [WORD_BITS];
  logic [DV_BITS-1:0]   rem_d   [WORD_BITS];
  logic [WORD_BITS-1:0] quo_d   [WORD_BITS];

  always_comb begin
    rem_in[0] = DV_BITS'(m_i);
    quo_in[0] = '0;
    a_in[0]   = a_i;
    for (int k = 1; k < WORD_BITS; k++) begin
      rem_in[k] = rem_q[k-1];
      quo_in[k] = quo_q[k-1];
      a_in[k]   = a_q[k-1];
    end
    for (int k = 0; k < WORD_BITS; k++) begin
      sh_c[k]  = DV_BITS'(a_in[k]) << (WORD_BITS - 1 - k);
      ge_c[k]  = rem_in[k] >= sh_c[k];
      rem_d[k] = ge_c[k] ? rem_in[k] - sh_c[k] : rem_in[k];
      quo_d[k] = {quo_in[k][WORD_BITS-2:0], ge_c[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WORD_BITS; k++) valid_q[k] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int k = 1; k < WORD_BITS; k++) valid_q[k] <= valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < WORD_BITS; k++) side_q[k] <= side_q[k-1];
      for (int k = 0; k < WORD_BITS; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        a_q[k]   <= a_in[k];
      end
    end
  end

  assign valid_o = valid_q[WORD_BITS-1];
  assign q_o     = quo_q[WORD_BITS-1];
  assign side_o  = side_q[WORD_BITS-1];

endmodule

`default_nettype wire

@@ src/ball_pair_collision_time_unit.sv @@
// Operands and the impact time are Q16.16 fixed point.
// Throughput: one transaction per cycle while the output is not stalled; every stage advances together.
// Six front stages form the quadratic coefficients and discriminant, then one
// square root digit per stage, one numerator stage, one quotient bit per stage.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none

module ball_pair_collision_time_unit import ballc_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_radius,
  // b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius, zero fill
  input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  // impact_time
  output logic [OUT_TDATA_BITS-1:0]      m_axis_tdata_o,
  // hit
  output logic [0:0]                     m_axis_tuser_o
);

  logic en;

  // stage 1: differences
  logic                        v1_q;
  logic signed [DIFF_BITS-1:0] vdx1_q, vdy1_q, pdx1_q, pdy1_q;
  logic [WORD_BITS-1:0]        d1_q;
  logic signed [DIFF_BITS-1:0] vdx_c, vdy_c, pdx_c, pdy_c;
  logic [WORD_BITS-1:0]        d_c;

  // stage 2: products
  logic                         v2_q;
  logic signed [2*DIFF_BITS-1:0] vxx2_q, vyy2_q, vxp2_q, vyp2_q, pxx2_q, pyy2_q;
  logic [2*WORD_BITS-1:0]       dd2_q;

  // stage 3: coefficients
  logic                     v3_q;
  logic [A_BITS-1:0]        a3_q;
  logic signed [B_BITS-1:0] b3_q, c3_q;

  // stage 4: partial products
  logic                      v4_q;
  logic [MAG_BITS-1:0]       bmag_c, cmag_c;
  logic [2*HALF_BITS-1:0]    bll4_q, blh4_q, bhh4_q, all4_q, alh4_q, ahl4_q, ahh4_q;
  logic [A_BITS-1:0]         a4_q;
  logic signed [B_BITS-1:0]  b4_q;
  logic                      azero4_q, cneg4_q, czero4_q, ble4_q;

  // stage 5: b*b and a*|c|
  logic                      v5_q;
  logic [PROD_BITS-1:0]      bsq5_q, ac5_q;
  logic [A_BITS-1:0]         a5_q;
  logic signed [B_BITS-1:0]  b5_q;
  logic                      azero5_q, cneg5_q, czero5_q, ble5_q;

  // stage 6: discriminant and root selection
  logic                         v6_q;
  logic [RAD_IN_BITS-1:0]       x6_q;
  sq_side_t                     side6_q;
  logic signed [DISC_BITS-1:0]  bsq_s, ac_s, disc_c;
  logic                         dneg_c;

  logic                 sq_valid;
  logic [SQ_DIGITS-1:0] sq_root;
  logic                 sq_exact;
  sq_side_t             sq_side;

  // numerator stage
  logic                      vm_q;
  logic [MU_BITS-1:0]        mu_q;
  logic [A_BITS-1:0]         am_q;
  dv_side_t                  sidem_q;
  logic signed [M_BITS-1:0]  mneg_c, root_c, inc_c, m_c;
  logic [MU_BITS-1:0]        mu_c;
  logic                      sat_c;

  logic                 dv_valid;
  logic [WORD_BITS-1:0] dv_q;
  dv_side_t             dv_side;
  logic [WORD_BITS-1:0] time_c;

  assign en              = !dv_valid || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_comb begin
    vdx_c = DIFF_BITS'($signed(s_axis_tdata_i[OFF_A_VEL_X +: WORD_BITS]))
          - DIFF_BITS'($signed(s_axis_tdata_i[OFF_B_VEL_X +: WORD_BITS]));
    vdy_c = DIFF_BITS'($signed(s_axis_tdata_i[OFF_A_VEL_Y +: WORD_BITS]))
          - DIFF_BITS'($signed(s_axis_tdata_i[OFF_B_VEL_Y +: WORD_BITS]));
    pdx_c = DIFF_BITS'($signed(s_axis_tdata_i[OFF_A_POS_X +: WORD_BITS]))
          - DIFF_BITS'($signed(s_axis_tdata_i[OFF_B_POS_X +: WORD_BITS]));
    pdy_c = DIFF_BITS'($signed(s_axis_tdata_i[OFF_A_POS_Y +: WORD_BITS]))
          - DIFF_BITS'($signed(s_axis_tdata_i[OFF_B_POS_Y +: WORD_BITS]));
    d_c   = WORD_BITS'(s_axis_tdata_i[OFF_A_RAD +: RAD_BITS])
          + WORD_BITS'(s_axis_tdata_i[OFF_B_RAD +: RAD_BITS]);
  end

  always_comb begin
    bmag_c = b3_q[B_BITS-1] ? MAG_BITS'(-b3_q) : MAG_BITS'(b3_q);
    cmag_c = c3_q[B_BITS-1] ? MAG_BITS'(-c3_q) : MAG_BITS'(c3_q);
  end

  always_comb begin
    bsq_s  = $signed({1'b0, bsq5_q});
    ac_s   = $signed({1'b0, ac5_q});
    disc_c = cneg5_q ? bsq_s + ac_s : bsq_s - ac_s;
    dneg_c = disc_c[DISC_BITS-1];
  end

  always_comb begin
    mneg_c = (-M_BITS'(sq_side.b)) <<< FRAC_BITS;
    root_c = $signed(M_BITS'(sq_root));
    inc_c  = sq_exact ? M_BITS'(0) : M_BITS'(1);
    m_c    = sq_side.enter ? mneg_c - root_c - inc_c : mneg_c + root_c;
    mu_c   = m_c[M_BITS-1] ? '0 : m_c[MU_BITS-1:0];
    sat_c  = DV_BITS'(mu_c) >= (DV_BITS'(sq_side.a) << WORD_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      vm_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      vm_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vdx1_q <= vdx_c;
      vdy1_q <= vdy_c;
      pdx1_q <= pdx_c;
      pdy1_q <= pdy_c;
      d1_q   <= d_c;

      vxx2_q <= vdx1_q * vdx1_q;
      vyy2_q <= vdy1_q * vdy1_q;
      vxp2_q <= vdx1_q * pdx1_q;
      vyp2_q <= vdy1_q * pdy1_q;
      pxx2_q <= pdx1_q * pdx1_q;
      pyy2_q <= pdy1_q * pdy1_q;
      dd2_q  <= d1_q * d1_q;

      a3_q <= A_BITS'($unsigned(vxx2_q)) + A_BITS'($unsigned(vyy2_q));
      b3_q <= B_BITS'(vxp2_q) + B_BITS'(vyp2_q);
      c3_q <= B_BITS'(pxx2_q) + B_BITS'(pyy2_q) - B_BITS'($signed({1'b0, dd2_q}));

      bll4_q   <= bmag_c[HALF_BITS-1:0] * bmag_c[HALF_BITS-1:0];
      blh4_q   <= bmag_c[HALF_BITS-1:0] * bmag_c[MAG_BITS-1:HALF_BITS];
      bhh4_q   <= bmag_c[MAG_BITS-1:HALF_BITS] * bmag_c[MAG_BITS-1:HALF_BITS];
      all4_q   <= a3_q[HALF_BITS-1:0] * cmag_c[HALF_BITS-1:0];
      alh4_q   <= a3_q[HALF_BITS-1:0] * cmag_c[MAG_BITS-1:HALF_BITS];
      ahl4_q   <= a3_q[A_BITS-1:HALF_BITS] * cmag_c[HALF_BITS-1:0];
      ahh4_q   <= a3_q[A_BITS-1:HALF_BITS] * cmag_c[MAG_BITS-1:HALF_BITS];
      a4_q     <= a3_q;
      b4_q     <= b3_q;
      azero4_q <= a3_q == '0;
      cneg4_q  <= c3_q[B_BITS-1];
      czero4_q <= c3_q == '0;
      ble4_q   <= b3_q[B_BITS-1] || (b3_q == '0);

      bsq5_q   <= PROD_BITS'(bll4_q)
                + (PROD_BITS'(blh4_q) << (HALF_BITS + 1))
                + (PROD_BITS'(bhh4_q) << (2 * HALF_BITS));
      ac5_q    <= PROD_BITS'(all4_q)
                + ((PROD_BITS'(alh4_q) + PROD_BITS'(ahl4_q)) << HALF_BITS)
                + (PROD_BITS'(ahh4_q) << (2 * HALF_BITS));
      a5_q     <= a4_q;
      b5_q     <= b4_q;
      azero5_q <= azero4_q;
      cneg5_q  <= cneg4_q;
      czero5_q <= czero4_q;
      ble5_q   <= ble4_q;

      x6_q          <= dneg_c ? '0
                     : RAD_IN_BITS'(disc_c[DISC_BITS-2:0]) << (2 * FRAC_BITS);
      side6_q.hit   <= !azero5_q && !dneg_c && (ble5_q || cneg5_q || czero5_q);
      side6_q.enter <= ble5_q && !cneg5_q;
      side6_q.a     <= a5_q;
      side6_q.b     <= b5_q;

      mu_q        <= mu_c;
      am_q        <= sq_side.a;
      sidem_q.hit <= sq_side.hit;
      sidem_q.sat <= sat_c;
    end
  end

  ballc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .x_i     (x6_q),
    .side_i  (side6_q),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .exact_o (sq_exact),
    .side_o  (sq_side)
  );

  ballc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vm_q),
    .m_i     (mu_q),
    .a_i     (am_q),
    .side_i  (sidem_q),
    .valid_o (dv_valid),
    .q_o     (dv_q),
    .side_o  (dv_side)
  );

  assign time_c          = (dv_side.hit && !dv_side.sat) ? dv_q : '1;
  assign m_axis_tvalid_o = dv_valid;
  assign m_axis_tdata_o  = OUT_TDATA_BITS'(time_c);
  assign m_axis_tuser_o  = dv_side.hit;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench import ballc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_PAIRS   = 1650;
  localparam int unsigned QUIET_TAIL  = 150;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN       = 160;
  localparam logic [WORD_BITS-1:0] T_MAX = '1;
  localparam logic [WORD_BITS-1:0] ONE   = 1 << FRAC_BITS;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [WORD_BITS-1:0] apx, apy, avx, avy;
    logic [RAD_BITS-1:0]         ar;
    logic signed [WORD_BITS-1:0] bpx, bpy, bvx, bvy;
    logic [RAD_BITS-1:0]         br;
  } pair_t;

  typedef struct {
    logic                 hit;
    logic [WORD_BITS-1:0] t;
  } impact_t;

  typedef struct {
    pair_t   p;
    bit      known;
    impact_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [IN_TDATA_BITS-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata_o;
  logic [0:0] m_axis_tuser_o;

  impact_t impact_q[$];
  int unsigned errors = 0;
  bit quiet = 0;
  bit hold_req = 0;

  ball_pair_collision_time_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic logic [IN_TDATA_BITS-1:0] pack_pair(pair_t p);
    logic [IN_TDATA_BITS-1:0] v;
    v = '0;
    v[OFF_A_POS_X +: WORD_BITS] = p.apx;
    v[OFF_A_POS_Y +: WORD_BITS] = p.apy;
    v[OFF_A_VEL_X +: WORD_BITS] = p.avx;
    v[OFF_A_VEL_Y +: WORD_BITS] = p.avy;
    v[OFF_A_RAD +: RAD_BITS]    = p.ar;
    v[OFF_B_POS_X +: WORD_BITS] = p.bpx;
    v[OFF_B_POS_Y +: WORD_BITS] = p.bpy;
    v[OFF_B_VEL_X +: WORD_BITS] = p.bvx;
    v[OFF_B_VEL_Y +: WORD_BITS] = p.bvy;
    v[OFF_B_RAD +: RAD_BITS]    = p.br;
    return v;
  endfunction

  function automatic wide_t floor_sqrt(wide_t n_in, output bit exact);
    logic [255:0] n, res, bt;
    n = n_in;
    res = '0;
    bt = 256'b1 << 254;
    while (bt != 0 && bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    exact = (n == 0);
    return wide_t'(res);
  endfunction

  function automatic impact_t impact_of(pair_t p);
    wide_t vdx, vdy, pdx, pdy, d, qa, qb, qc, disc, s, m, q;
    bit exact, le_b, enter;
    impact_t r;
    vdx = wide_t'(p.avx) - wide_t'(p.bvx);
    vdy = wide_t'(p.avy) - wide_t'(p.bvy);
    pdx = wide_t'(p.apx) - wide_t'(p.bpx);
    pdy = wide_t'(p.apy) - wide_t'(p.bpy);
    d   = wide_t'({1'b0, p.ar}) + wide_t'({1'b0, p.br});
    qa  = vdx * vdx + vdy * vdy;
    qb  = vdx * pdx + vdy * pdy;
    qc  = pdx * pdx + pdy * pdy - d * d;
    r.hit = 1'b0;
    r.t = T_MAX;
    if (qa == 0) return r;
    disc = qb * qb - qa * qc;
    if (disc < 0) return r;
    le_b = (qb <= 0);
    if (le_b && qc >= 0) enter = 1;
    else if (le_b || qc <= 0) enter = 0;
    else return r;
    s = floor_sqrt(disc <<< (2 * FRAC_BITS), exact);
    m = (-qb) <<< FRAC_BITS;
    if (enter) m = m - s - (exact ? 0 : 1);
    else m = m + s;
    if (m < 0) m = 0;
    r.hit = 1'b1;
    if (m >= (qa <<< WORD_BITS)) begin
      r.t = T_MAX;
    end else begin
      q = m / qa;
      r.t = q[WORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic pair_t mk(int apx, int apy, int avx, int avy, int unsigned ar,
                               int bpx, int bpy, int bvx, int bvy, int unsigned br);
    pair_t p;
    p.apx = apx; p.apy = apy; p.avx = avx; p.avy = avy; p.ar = ar[RAD_BITS-1:0];
    p.bpx = bpx; p.bpy = bpy; p.bvx = bvx; p.bvy = bvy; p.br = br[RAD_BITS-1:0];
    return p;
  endfunction

  function automatic logic signed [WORD_BITS-1:0] rnd_span(int unsigned bits);
    logic signed [WORD_BITS-1:0] v;
    v = $urandom;
    return v >>> (WORD_BITS - bits);
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int unsigned ps, vs, rs;
    if ($urandom_range(0, 3) == 0) begin
      ps = 32; vs = 32; rs = 31;
    end else begin
      ps = $urandom_range(12, 26);
      vs = $urandom_range(8, ps);
      rs = $urandom_range(4, ps - 2);
    end
    p.apx = rnd_span(ps); p.apy = rnd_span(ps);
    p.avx = rnd_span(vs); p.avy = rnd_span(vs);
    p.bpx = rnd_span(ps); p.bpy = rnd_span(ps);
    p.bvx = rnd_span(vs); p.bvy = rnd_span(vs);
    p.ar = RAD_BITS'($urandom >> (32 - rs));
    p.br = RAD_BITS'($urandom >> (32 - rs));
    if ($urandom_range(0, 15) == 0) begin
      p.bvx = p.avx;
      p.bvy = p.avy;
    end
    return p;
  endfunction

  task automatic send_pair(pair_t p, bit known, impact_t want);
    bit acc;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= pack_pair(p);
    do begin
      @(negedge clk_i);
      acc = s_axis_tready_o;
      @(posedge clk_i);
    end while (!acc);
    impact_q.insert(impact_q.size(), known ? want : impact_of(p));
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic flag_mismatch(string what, logic [WORD_BITS-1:0] want,
                               logic [WORD_BITS-1:0] got);
    if (errors < 10) $display("mismatch %s: expected %h actual %h", what, want, got);
    errors++;
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (!rst_ni || quiet) begin
        m_axis_tready_i <= 1'b1;
      end else if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 0;
      end else if ($urandom_range(0, 9) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(negedge clk_i) begin
    impact_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (impact_q.size() == 0) begin
        flag_mismatch("unexpected result", '0, m_axis_tdata_o[WORD_BITS-1:0]);
      end else begin
        want = impact_q.pop_front();
        if (m_axis_tuser_o[0] !== want.hit)
          flag_mismatch("hit", want.hit, m_axis_tuser_o[0]);
        if (m_axis_tdata_o[WORD_BITS-1:0] !== want.t)
          flag_mismatch("impact_time", want.t, m_axis_tdata_o[WORD_BITS-1:0]);
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    impact_t none;
    int unsigned sent;
    int unsigned wait_cnt;
    int smin, smax;
    smin = 32'sh8000_0000;
    smax = 32'sh7fff_ffff;
    none.hit = 1'b0;
    none.t = T_MAX;

    r.known = 1; r.want = none;
    r.p = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    rows.insert(rows.size(), r);
    r.p = mk(0, 0, ONE, ONE, ONE, 5 * ONE, 0, ONE, ONE, ONE);
    rows.insert(rows.size(), r);
    r.p = mk(0, 0, -ONE, 0, ONE, 10 * ONE, 0, 0, 0, ONE);
    rows.insert(rows.size(), r);
    r.p = mk(0, 0, ONE, 0, ONE, 10 * ONE, 10 * ONE, 0, 0, ONE);
    rows.insert(rows.size(), r);
    r.want.hit = 1'b1;
    r.want.t = 8 * ONE;
    r.p = mk(0, 0, ONE, 0, ONE, 10 * ONE, 0, 0, 0, ONE);
    rows.insert(rows.size(), r);
    r.want.t = 3 * ONE;
    r.p = mk(0, 0, -ONE, 0, 2 * ONE, ONE, 0, 0, 0, 2 * ONE);
    rows.insert(rows.size(), r);
    r.want.t = 0;
    r.p = mk(0, 0, ONE, 0, ONE, 2 * ONE, 0, 0, 0, ONE);
    rows.insert(rows.size(), r);
    r.want.t = T_MAX;
    r.p = mk(0, 0, 1, 0, 0, 32'sh7fff_0000, 0, 0, 0, 0);
    rows.insert(rows.size(), r);

    r.known = 0;
    r.p = mk(smax, smax, smin, smin, 32'h7fff_ffff, smin, smin, smax, smax, 32'h7fff_ffff);
    rows.insert(rows.size(), r);
    r.p = mk(smin, smin, smin, smin, 0, smin, smin, smin, smin, 0);
    rows.insert(rows.size(), r);
    r.p = mk(smax, smax, smax, smax, 32'h7fff_ffff, smax, smax, smax, smax, 32'h7fff_ffff);
    rows.insert(rows.size(), r);
    r.p = mk(smin, smax, smax, smin, 0, smax, smin, smin, smax, 32'h7fff_ffff);
    rows.insert(rows.size(), r);
    r.p = mk(smin, 0, smax, 0, 1, smax, 0, smin, 0, 1);
    rows.insert(rows.size(), r);
    r.p = mk(-1, -1, 1, -1, 32'h7fff_ffff, 1, 1, -1, 1, 0);
    rows.insert(rows.size(), r);
    r.p = mk(3 * ONE, -4 * ONE, -ONE / 2, ONE, ONE / 3, -2 * ONE, 7 * ONE, ONE / 5, -ONE,
             ONE / 7);
    rows.insert(rows.size(), r);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sent = 0;
    foreach (rows[i]) begin
      send_pair(rows[i].p, rows[i].known, rows[i].want);
      sent++;
    end
    while (sent < NUM_PAIRS) begin
      if (sent == 300) hold_req = 1;
      if (sent == 700) begin
        s_axis_tvalid_i <= 1'b0;
        while (impact_q.size() != 0) @(posedge clk_i);
      end
      if (sent >= NUM_PAIRS - QUIET_TAIL) quiet = 1;
      send_pair(random_pair(), 0, none);
      sent++;
    end
    s_axis_tvalid_i <= 1'b0;

    wait_cnt = 0;
    while (impact_q.size() != 0 && wait_cnt < 200_000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    if (impact_q.size() != 0) errors++;
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
src/ballc_pkg.sv
src/ballc_sqrt.sv
src/ballc_div.sv
src/ball_pair_collision_time_unit.sv
tb/testbench.sv
